[sv/lfs_pkg.sv]
package lfs_pkg;

    localparam int PAT_W   = 8;
    localparam int SPEED_W = 8;
    localparam int DRIVE_W = 9;
    localparam int MODE_W  = 2;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 24;

    localparam logic [SPEED_W-1:0] MAX_SPEED_RST  = 8'd200;
    localparam logic [SPEED_W-1:0] SPIN_SPEED_RST = 8'd100;

    localparam logic [PAT_W-1:0] MIDDLE_MASK = 8'b0001_1000;
    localparam logic [PAT_W-1:0] LEFT_OUTER  = 8'b1000_0000;
    localparam logic [PAT_W-1:0] RIGHT_OUTER = 8'b0000_0001;

    typedef enum logic [MODE_W-1:0] {
        MODE_FOLLOW = 2'd0,
        MODE_TRACK  = 2'd1,
        MODE_SPIN   = 2'd2
    } mode_t;

    typedef enum logic {
        SIDE_LEFT  = 1'b0,
        SIDE_RIGHT = 1'b1
    } side_t;

    typedef enum logic {
        REG_MAX_SPEED  = 1'b0,
        REG_SPIN_SPEED = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic                      hit;
        logic signed [DRIVE_W-1:0] left;
        logic signed [DRIVE_W-1:0] right;
    } steer_t;

    typedef struct packed {
        logic [MODE_W-1:0]         mode;
        side_t                     side;
        logic signed [DRIVE_W-1:0] left;
        logic signed [DRIVE_W-1:0] right;
    } state_t;

endpackage

[sv/lfs_steer.sv]
module lfs_steer import lfs_pkg::*; (
    input  logic [PAT_W-1:0]   pattern,
    input  logic [SPEED_W-1:0] max_speed,
    output steer_t             steer
);

    logic [SPEED_W+1:0]        prod3;
    logic signed [DRIVE_W-1:0] m;
    logic signed [DRIVE_W-1:0] q3;
    logic signed [DRIVE_W-1:0] h;
    logic signed [DRIVE_W-1:0] q;

    assign prod3 = {2'b00, max_speed} + {1'b0, max_speed, 1'b0};
    assign m     = {1'b0, max_speed};
    assign q3    = {1'b0, prod3[SPEED_W+1:2]};
    assign h     = {2'b00, max_speed[SPEED_W-1:1]};
    assign q     = {3'b000, max_speed[SPEED_W-1:2]};

    always_comb begin
        steer.hit   = 1'b1;
        steer.left  = '0;
        steer.right = '0;
        case (pattern)
            8'h80: begin steer.left = -q3; steer.right = m;   end
            8'h01: begin steer.left = m;   steer.right = -q3; end
            8'h18: begin steer.left = m;   steer.right = m;   end
            8'hC0: begin steer.left = -h;  steer.right = m;   end
            8'h03: begin steer.left = m;   steer.right = -h;  end
            8'h60: begin steer.left = '0;  steer.right = m;   end
            8'h06: begin steer.left = m;   steer.right = '0;  end
            8'h0C: begin steer.left = m;   steer.right = h;   end
            8'h30: begin steer.left = h;   steer.right = m;   end
            8'hE0: begin steer.left = -q;  steer.right = m;   end
            8'h07: begin steer.left = m;   steer.right = -q;  end
            8'h70: begin steer.left = q;   steer.right = m;   end
            8'h0E: begin steer.left = m;   steer.right = q;   end
            8'h38: begin steer.left = h;   steer.right = m;   end
            8'h1C: begin steer.left = m;   steer.right = h;   end
            default: steer.hit = 1'b0;
        endcase
    end

endmodule

[sv/lfs_step.sv]
module lfs_step import lfs_pkg::*; (
    input  logic [PAT_W-1:0]   pattern,
    input  logic               front_seen,
    input  logic [SPEED_W-1:0] max_speed,
    input  logic [SPEED_W-1:0] spin_speed,
    input  state_t             cur,
    output state_t             nxt
);

    steer_t                    steer;
    logic                      turn_hit;
    logic                      turn_acute;
    side_t                     turn_side;
    logic [3:0]                ones;
    logic                      middle;
    logic                      away;
    logic signed [DRIVE_W-1:0] s;
    logic signed [DRIVE_W-1:0] m;

    lfs_steer u_steer (
        .pattern   (pattern),
        .max_speed (max_speed),
        .steer     (steer)
    );

    assign s      = {1'b0, spin_speed};
    assign m      = {1'b0, max_speed};
    assign middle = |(pattern & MIDDLE_MASK);
    assign away   = (cur.side == SIDE_LEFT) ? |(pattern & RIGHT_OUTER)
                                            : |(pattern & LEFT_OUTER);

    always_comb begin
        ones = '0;
        for (int i = 0; i < PAT_W; i++) begin
            ones = ones + {3'b000, pattern[i]};
        end
    end

    always_comb begin
        turn_hit   = 1'b1;
        turn_acute = 1'b0;
        turn_side  = SIDE_LEFT;
        case (pattern)
            8'hF0, 8'h78, 8'h3C, 8'hE8, 8'hB8, 8'hF8, 8'h7C,
            8'hEC, 8'hE6, 8'hBC, 8'hDC, 8'hFC, 8'h7E: begin
                turn_side = SIDE_LEFT;
            end
            8'h0F, 8'h1E, 8'h17, 8'h1D, 8'h1F, 8'h3E,
            8'h37, 8'h67, 8'h3D, 8'h3B, 8'h3F: begin
                turn_side = SIDE_RIGHT;
            end
            8'h19, 8'h0D, 8'h31, 8'h33, 8'h1B, 8'h39: begin
                turn_acute = 1'b1;
                turn_side  = SIDE_RIGHT;
            end
            8'h98, 8'hB0, 8'h8C, 8'hCC, 8'hD8, 8'h9C: begin
                turn_acute = 1'b1;
                turn_side  = SIDE_LEFT;
            end
            default: begin
                turn_hit = (ones >= 4'd7);
            end
        endcase
    end

    always_comb begin
        nxt = cur;
        case (cur.mode)
            MODE_TRACK: begin
                if (away) begin
                    nxt.mode = MODE_FOLLOW;
                end else begin
                    if (steer.hit) begin
                        nxt.left  = steer.left;
                        nxt.right = steer.right;
                    end
                    if (!middle) begin
                        nxt.mode = MODE_SPIN;
                        if (cur.side == SIDE_RIGHT) begin
                            nxt.left  = s;
                            nxt.right = -s;
                        end else begin
                            nxt.left  = -s;
                            nxt.right = s;
                        end
                    end
                end
            end
            MODE_SPIN: begin
                if (middle) begin
                    nxt.mode = MODE_FOLLOW;
                end
            end
            default: begin
                nxt.mode = MODE_FOLLOW;
                if (steer.hit) begin
                    nxt.left  = steer.left;
                    nxt.right = steer.right;
                end else if (turn_hit) begin
                    if (!turn_acute) begin
                        nxt.left  = m;
                        nxt.right = m;
                    end
                    if (turn_acute || !front_seen) begin
                        nxt.side = turn_side;
                        nxt.mode = MODE_TRACK;
                    end
                end
            end
        endcase
    end

endmodule

[sv/line_follow_steering_fsm_top.sv]
// A result beat is registered and appears on the master side in the cycle after its input beat is taken.
// Throughput: one sample per cycle while m_tready holds; the single result register is refilled while it drains.
// Reset: synchronous, active low; mode returns to follow, turn side to left, both drives
// to zero, max_speed to 200, spin_speed to 100, and the result register empties.
module line_follow_steering_fsm_top import lfs_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic                 cfg_index,
    input  logic [SPEED_W-1:0]   cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // Fields from bit 0: sensor_pattern[7:0], front_seen[8], zero fill.
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // Fields from bit 0: left_drive[8:0], right_drive[17:9], mode_now[19:18], zero fill.
    output logic [M_TDATA_W-1:0] m_tdata
);

    logic [SPEED_W-1:0]   max_speed_reg;
    logic [SPEED_W-1:0]   spin_speed_reg;
    state_t               state_reg;
    state_t               state_next;
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                 s_beat;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_beat   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    lfs_step u_step (
        .pattern    (s_tdata[PAT_W-1:0]),
        .front_seen (s_tdata[PAT_W]),
        .max_speed  (max_speed_reg),
        .spin_speed (spin_speed_reg),
        .cur        (state_reg),
        .nxt        (state_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_speed_reg  <= MAX_SPEED_RST;
            spin_speed_reg <= SPIN_SPEED_RST;
        end else if (cfg_wr_en) begin
            case (reg_idx_t'(cfg_index))
                REG_MAX_SPEED:  max_speed_reg  <= cfg_wdata;
                REG_SPIN_SPEED: spin_speed_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= '{mode: MODE_FOLLOW, side: SIDE_LEFT, left: '0, right: '0};
            m_tvalid_reg <= 1'b0;
        end else begin
            if (s_beat) begin
                state_reg    <= state_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_beat) begin
            m_tdata_reg <= {{(M_TDATA_W - 2*DRIVE_W - MODE_W){1'b0}},
                            state_next.mode, state_next.right, state_next.left};
        end
    end

endmodule

[sv/lfs_checker.sv]
module lfs_checker import lfs_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    logic [DRIVE_W-1:0] drive_sum;

    assign drive_sum = m_tdata[DRIVE_W-1:0] + m_tdata[2*DRIVE_W-1:DRIVE_W];

    a_no_bad_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[2*DRIVE_W+MODE_W-1:2*DRIVE_W] != 2'd3))
        else $error("result beat carries an unused mode code");

    a_spin_opposed: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[2*DRIVE_W+MODE_W-1:2*DRIVE_W] == MODE_SPIN))
            |-> (drive_sum == '0))
        else $error("spin drives are not equal and opposite");

    a_ready_rule: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow the result register");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result beat valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result beat changed");

endmodule

bind line_follow_steering_fsm_top lfs_checker u_lfs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[sim/line_follow_steering_fsm_top_tb.sv]
module line_follow_steering_fsm_top_tb import lfs_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] left;
        logic signed [DRIVE_W-1:0] right;
        logic [MODE_W-1:0]         mode;
    } drive_res_t;

    typedef struct {
        logic [PAT_W-1:0] pat;
        logic             front;
        logic             typed;
        drive_res_t       res;
    } sample_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic                 cfg_index = REG_MAX_SPEED;
    logic [SPEED_W-1:0]   cfg_wdata = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    // Predicted block state.
    logic [SPEED_W-1:0]        cur_max = MAX_SPEED_RST;
    logic [SPEED_W-1:0]        cur_spin = SPIN_SPEED_RST;
    mode_t                     cur_mode = MODE_FOLLOW;
    side_t                     cur_side = SIDE_LEFT;
    logic signed [DRIVE_W-1:0] cur_left = '0;
    logic signed [DRIVE_W-1:0] cur_right = '0;

    drive_res_t  drive_q [$];
    sample_row_t directed_rows [$];
    int          fail_count = 0;
    int          results_seen = 0;
    logic        tx_gaps = 1'b1;
    logic        rx_gaps = 1'b1;
    logic        squeezed = 1'b0;

    logic [PAT_W-1:0] steer_pats [0:14] = '{8'h80, 8'h01, 8'h18, 8'hC0, 8'h03, 8'h60, 8'h06,
        8'h0C, 8'h30, 8'hE0, 8'h07, 8'h70, 8'h0E, 8'h38, 8'h1C};
    logic [PAT_W-1:0] turn_pats [0:23] = '{8'hF0, 8'h78, 8'h3C, 8'hE8, 8'hB8, 8'hF8, 8'h7C,
        8'hEC, 8'hE6, 8'hBC, 8'hDC, 8'hFC, 8'h7E, 8'h0F, 8'h1E, 8'h17, 8'h1D, 8'h1F, 8'h3E,
        8'h37, 8'h67, 8'h3D, 8'h3B, 8'h3F};
    logic [PAT_W-1:0] acute_pats [0:11] = '{8'h19, 8'h98, 8'hB0, 8'h0D, 8'h8C, 8'h31, 8'h33,
        8'hCC, 8'hD8, 8'h1B, 8'h9C, 8'h39};

    line_follow_steering_fsm_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 aclk = ~aclk;

    function automatic void steer_lookup(input logic [PAT_W-1:0] pat, output logic hit,
                                         output int l, output int r);
        int m;
        int q3;
        int h;
        int q;
        m  = int'(cur_max);
        q3 = (3 * int'(cur_max)) >> 2;
        h  = int'(cur_max) >> 1;
        q  = int'(cur_max) >> 2;
        hit = 1'b1;
        l = 0;
        r = 0;
        case (pat)
            8'h80: begin l = -q3; r = m; end
            8'h01: begin l = m; r = -q3; end
            8'h18: begin l = m; r = m; end
            8'hC0: begin l = -h; r = m; end
            8'h03: begin l = m; r = -h; end
            8'h60: begin l = 0; r = m; end
            8'h06: begin l = m; r = 0; end
            8'h0C: begin l = m; r = h; end
            8'h30: begin l = h; r = m; end
            8'hE0: begin l = -q; r = m; end
            8'h07: begin l = m; r = -q; end
            8'h70: begin l = q; r = m; end
            8'h0E: begin l = m; r = q; end
            8'h38: begin l = h; r = m; end
            8'h1C: begin l = m; r = h; end
            default: hit = 1'b0;
        endcase
    endfunction

    function automatic void turn_lookup(input logic [PAT_W-1:0] pat, output logic hit,
                                        output logic acute, output side_t side);
        hit = 1'b1;
        acute = 1'b0;
        side = SIDE_LEFT;
        case (pat)
            8'hF0, 8'h78, 8'h3C, 8'hE8, 8'hB8, 8'hF8, 8'h7C, 8'hEC, 8'hE6, 8'hBC, 8'hDC,
            8'hFC, 8'h7E: side = SIDE_LEFT;
            8'h0F, 8'h1E, 8'h17, 8'h1D, 8'h1F, 8'h3E, 8'h37, 8'h67, 8'h3D, 8'h3B,
            8'h3F: side = SIDE_RIGHT;
            8'h98, 8'hB0, 8'h8C, 8'hCC, 8'hD8, 8'h9C: acute = 1'b1;
            8'h19, 8'h0D, 8'h31, 8'h33, 8'h1B, 8'h39: begin
                acute = 1'b1;
                side = SIDE_RIGHT;
            end
            default: hit = 1'b0;
        endcase
    endfunction

    function automatic drive_res_t advance_steering(input logic [PAT_W-1:0] pat,
                                                    input logic front);
        logic       hit;
        logic       acute;
        side_t      side;
        int         l;
        int         r;
        drive_res_t res;
        steer_lookup(pat, hit, l, r);
        case (cur_mode)
            MODE_TRACK: begin
                if ((cur_side == SIDE_LEFT) ? pat[0] : pat[7]) begin
                    cur_mode = MODE_FOLLOW;
                end else begin
                    if (hit) begin
                        cur_left = DRIVE_W'(l);
                        cur_right = DRIVE_W'(r);
                    end
                    if ((pat & MIDDLE_MASK) == '0) begin
                        if (cur_side == SIDE_RIGHT) begin
                            cur_left = DRIVE_W'(int'(cur_spin));
                            cur_right = DRIVE_W'(-int'(cur_spin));
                        end else begin
                            cur_left = DRIVE_W'(-int'(cur_spin));
                            cur_right = DRIVE_W'(int'(cur_spin));
                        end
                        cur_mode = MODE_SPIN;
                    end
                end
            end
            MODE_SPIN: begin
                if ((pat & MIDDLE_MASK) != '0) cur_mode = MODE_FOLLOW;
            end
            default: begin
                cur_mode = MODE_FOLLOW;
                if (hit) begin
                    cur_left = DRIVE_W'(l);
                    cur_right = DRIVE_W'(r);
                end else begin
                    turn_lookup(pat, hit, acute, side);
                    // A pattern with seven or more lit sensors counts as a left turn.
                    if (!hit && $countones(pat) >= 7) begin
                        hit = 1'b1;
                        acute = 1'b0;
                        side = SIDE_LEFT;
                    end
                    if (hit) begin
                        if (!acute) begin
                            cur_left = DRIVE_W'(int'(cur_max));
                            cur_right = DRIVE_W'(int'(cur_max));
                        end
                        if (acute || !front) begin
                            cur_side = side;
                            cur_mode = MODE_TRACK;
                        end
                    end
                end
            end
        endcase
        res.left = cur_left;
        res.right = cur_right;
        res.mode = cur_mode;
        return res;
    endfunction

    function automatic void add_row(input logic [PAT_W-1:0] pat, input logic front,
                                    input logic typed, input int l, input int r,
                                    input mode_t md);
        sample_row_t row;
        row.pat = pat;
        row.front = front;
        row.typed = typed;
        row.res.left = DRIVE_W'(l);
        row.res.right = DRIVE_W'(r);
        row.res.mode = md;
        directed_rows.push_back(row);
    endfunction

    task automatic offer(input logic [PAT_W-1:0] pat, input logic front, input logic typed,
                         input drive_res_t typed_res);
        drive_res_t res;
        if (tx_gaps && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {{(S_TDATA_W-PAT_W-1){1'b0}}, front, pat};
        @(posedge aclk);
        while (s_tready !== 1'b1) @(posedge aclk);
        res = advance_steering(pat, front);
        drive_q.push_back(typed ? typed_res : res);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (drive_q.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic set_speeds(input logic [SPEED_W-1:0] mx, input logic [SPEED_W-1:0] sp);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_MAX_SPEED;
        cfg_wdata <= mx;
        @(posedge aclk);
        cfg_index <= REG_SPIN_SPEED;
        cfg_wdata <= sp;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cur_max = mx;
        cur_spin = sp;
    endtask

    task automatic run_random(input int n);
        int               done_n;
        int               steps;
        logic [PAT_W-1:0] p;
        logic             f;
        drive_res_t       blank;
        done_n = 0;
        blank = '0;
        while (done_n < n) begin
            if ($urandom_range(0, 9) < 6) begin
                // Enter a turn, then walk the track and spin phases with fitting patterns.
                case ($urandom_range(0, 3))
                    0, 1: p = turn_pats[$urandom_range(0, 23)];
                    2: p = acute_pats[$urandom_range(0, 11)];
                    default: p = 8'hFF & ~(8'h01 << $urandom_range(0, 8));
                endcase
                f = ($urandom_range(0, 4) == 0);
                offer(p, f, 1'b0, blank);
                done_n++;
                steps = 0;
                while (cur_mode != MODE_FOLLOW && steps < 8 && done_n < n) begin
                    p = 8'($urandom_range(0, 255));
                    f = 1'($urandom_range(0, 1));
                    if (cur_mode == MODE_TRACK) begin
                        if ($urandom_range(0, 7) != 0)
                            p &= (cur_side == SIDE_LEFT) ? ~RIGHT_OUTER : ~LEFT_OUTER;
                        if ($urandom_range(0, 1) == 1) p &= ~MIDDLE_MASK;
                    end else if ($urandom_range(0, 2) != 0) begin
                        p &= ~MIDDLE_MASK;
                    end
                    offer(p, f, 1'b0, blank);
                    steps++;
                    done_n++;
                end
            end else begin
                p = ($urandom_range(0, 1) == 1) ? steer_pats[$urandom_range(0, 14)]
                                                 : 8'($urandom_range(0, 255));
                f = 1'($urandom_range(0, 1));
                offer(p, f, 1'b0, blank);
                done_n++;
            end
        end
    endtask

    initial begin
        int stall;
        drive_res_t got;
        drive_res_t want;
        stall = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid === 1'b1 && m_tready) begin
                got.left = m_tdata[DRIVE_W-1:0];
                got.right = m_tdata[2*DRIVE_W-1:DRIVE_W];
                got.mode = m_tdata[2*DRIVE_W+MODE_W-1:2*DRIVE_W];
                results_seen++;
                if (drive_q.size() == 0) begin
                    fail_count++;
                    $display("%0t: result beat with nothing expected, got %0d %0d mode %0d",
                             $realtime, got.left, got.right, got.mode);
                end else begin
                    want = drive_q.pop_front();
                    if (got.left !== want.left) begin
                        fail_count++;
                        $display("%0t: left_drive expected %0d got %0d", $realtime,
                                 want.left, got.left);
                    end
                    if (got.right !== want.right) begin
                        fail_count++;
                        $display("%0t: right_drive expected %0d got %0d", $realtime,
                                 want.right, got.right);
                    end
                    if (got.mode !== want.mode) begin
                        fail_count++;
                        $display("%0t: mode_now expected %0d got %0d", $realtime,
                                 want.mode, got.mode);
                    end
                end
            end
            // Hold the result side off for a long stretch once, so the input backs up.
            if (!squeezed && results_seen >= 400) begin
                stall = 80;
                squeezed = 1'b1;
            end else if (stall == 0 && rx_gaps && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(1, 18);
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                stall--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        add_row(8'h00, 1'b0, 1'b1, 0, 0, MODE_FOLLOW);
        add_row(8'h18, 1'b0, 1'b1, 200, 200, MODE_FOLLOW);
        add_row(8'h80, 1'b0, 1'b1, -150, 200, MODE_FOLLOW);
        add_row(8'h01, 1'b1, 1'b1, 200, -150, MODE_FOLLOW);
        add_row(8'hC0, 1'b0, 1'b0, 0, 0, MODE_FOLLOW);
        add_row(8'h03, 1'b1, 1'b0, 0, 0, MODE_FOLLOW);
        add_row(8'h60, 1'b0, 1'b0, 0, 0, MODE_FOLLOW);
        add_row(8'h06, 1'b0, 1'b0, 0, 0, MODE_FOLLOW);
        add_row(8'h0C, 1'b1, 1'b0, 0, 0, MODE_FOLLOW);
        add_row(8'h30, 1'b0, 1'b0, 0, 0, MODE_FOLLOW);
        add_row(8'hE0, 1'b0, 1'b0, 0, 0, MODE_FOLLOW);
        add_row(8'h07, 1'b1, 1'b0, 0, 0, MODE_FOLLOW);
        add_row(8'h70, 1'b0, 1'b0, 0, 0, MODE_FOLLOW);
        add_row(8'h0E, 1'b0, 1'b0, 0, 0, MODE_FOLLOW);
        add_row(8'h38, 1'b1, 1'b0, 0, 0, MODE_FOLLOW);
        add_row(8'h1C, 1'b0, 1'b0, 0, 0, MODE_FOLLOW);
        add_row(8'h42, 1'b0, 1'b0, 0, 0, MODE_FOLLOW);
        add_row(8'hF0, 1'b1, 1'b1, 200, 200, MODE_FOLLOW);
        add_row(8'h0F, 1'b0, 1'b1, 200, 200, MODE_TRACK);
        add_row(8'h80, 1'b0, 1'b0, 0, 0, MODE_FOLLOW);
        add_row(8'hFF, 1'b0, 1'b1, 200, 200, MODE_TRACK);
        add_row(8'h20, 1'b0, 1'b1, -100, 100, MODE_SPIN);
        add_row(8'h00, 1'b1, 1'b0, 0, 0, MODE_FOLLOW);
        add_row(8'h98, 1'b0, 1'b0, 0, 0, MODE_FOLLOW);
        add_row(8'h98, 1'b1, 1'b0, 0, 0, MODE_FOLLOW);
        add_row(8'h1C, 1'b0, 1'b0, 0, 0, MODE_FOLLOW);
        add_row(8'h00, 1'b0, 1'b0, 0, 0, MODE_FOLLOW);

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i])
            offer(directed_rows[i].pat, directed_rows[i].front, directed_rows[i].typed,
                  directed_rows[i].res);

        for (int ph = 0; ph < 6; ph++) begin
            drain();
            case (ph)
                0: set_speeds(8'd255, 8'd255);
                1: set_speeds(8'd0, 8'd0);
                2: set_speeds(8'($urandom_range(0, 255)), 8'd255);
                3: set_speeds(8'd255, 8'd0);
                default: set_speeds(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            endcase
            if (ph == 5) begin
                tx_gaps = 1'b0;
                rx_gaps = 1'b0;
            end
            run_random(170);
        end

        drain();
        repeat (5) @(posedge aclk);
        if (fail_count == 0 && drive_q.size() == 0) begin
            $display("line_follow_steering_fsm_top: match");
        end else begin
            $display("line_follow_steering_fsm_top: mismatch");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("line_follow_steering_fsm_top: mismatch");
        $finish;
    end

endmodule

[line_follow_steering_fsm_top.f]
sv/lfs_pkg.sv
sv/lfs_steer.sv
sv/lfs_step.sv
sv/line_follow_steering_fsm_top.sv
sv/lfs_checker.sv
sim/line_follow_steering_fsm_top_tb.sv
